// File: hdl/tgp_pkg.sv
// ----------------------------------------------------------------------------
// Turtle grid plotter package
// Shared widths, command codes and register map of the turtle grid plotter.
// ----------------------------------------------------------------------------
package tgp_pkg;

  localparam int GRID_SIZE_DEFAULT = 64;

  localparam int OP_W       = 3;
  localparam int DIST_W     = 8;
  localparam int COORD_W    = 6;
  localparam int HEAD_W     = 2;
  localparam int ROW_DATA_W = 64;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COORD_W-1:0] START_RESET = COORD_W'(24);

  typedef enum logic [OP_W-1:0] {
    OP_PEN_UP   = 3'd0,
    OP_PEN_DOWN = 3'd1,
    OP_RIGHT    = 3'd2,
    OP_LEFT     = 3'd3,
    OP_MOVE     = 3'd4,
    OP_PRINT    = 3'd5
  } op_t;

  localparam logic [HEAD_W-1:0] HEAD_ROW_UP   = 2'd0;
  localparam logic [HEAD_W-1:0] HEAD_COL_UP   = 2'd1;
  localparam logic [HEAD_W-1:0] HEAD_ROW_DOWN = 2'd2;
  localparam logic [HEAD_W-1:0] HEAD_COL_DOWN = 2'd3;

  localparam int REG_START_ROW = 0;
  localparam int REG_START_COL = 1;

endpackage

// File: hdl/tgp_cmd_if.sv
// ----------------------------------------------------------------------------
// Turtle grid plotter command channel
// Valid/ready channel carrying one command word per handshake.
// ----------------------------------------------------------------------------
interface tgp_cmd_if;
  import tgp_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [DIST_W-1:0] distance;

  modport source (output valid, output op, output distance, input ready);
  modport sink   (input valid, input op, input distance, output ready);

endinterface

// File: hdl/tgp_res_if.sv
// ----------------------------------------------------------------------------
// Turtle grid plotter result channel
// Valid/ready channel carrying one status or printed-row word per handshake.
// ----------------------------------------------------------------------------
interface tgp_res_if;
  import tgp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ROW_DATA_W-1:0] row_data;
  logic [COORD_W-1:0]    row_number;
  logic                  is_row;
  logic                  last;
  logic [COORD_W-1:0]    cur_row;
  logic [COORD_W-1:0]    cur_col;
  logic [HEAD_W-1:0]     cur_heading;
  logic                  pen_is_down;

  modport source (output valid, output row_data, output row_number, output is_row,
                  output last, output cur_row, output cur_col, output cur_heading,
                  output pen_is_down, input ready);
  modport sink   (input valid, input row_data, input row_number, input is_row,
                  input last, input cur_row, input cur_col, input cur_heading,
                  input pen_is_down, output ready);

endinterface

// File: hdl/tgp_ram.sv
// ----------------------------------------------------------------------------
// Turtle grid plotter RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tgp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/turtle_grid_plotter.sv
// ----------------------------------------------------------------------------
// Turtle grid plotter
// Turtle on a square bit grid held in RAM; draws with the pen down on move
// and prints the grid one row per result word.
// ----------------------------------------------------------------------------
// Pen and turn commands: status word ready in the cycle after acceptance.
// Move: each step goes through S_MOVE, and with the pen down also S_MARK
// (row read, then write through the single RAM port pair); a last S_MOVE
// finishes. Print: per row S_PRT_RD, S_PRT_WAIT, S_OUT (read, load, hand-off).
// One command is in flight at a time; a new one is taken once the last
// result word has gone. Reset clears every row-valid bit.
module turtle_grid_plotter #(
  parameter int GRID_SIZE = tgp_pkg::GRID_SIZE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tgp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tgp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tgp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  tgp_cmd_if.sink                       cmd,
  tgp_res_if.source                     res
);
  import tgp_pkg::*;

  localparam int ROW_W = $clog2(GRID_SIZE);
  localparam logic [COORD_W-1:0] LAST_COORD = COORD_W'(GRID_SIZE - 1);
  localparam logic [ROW_W-1:0]   LAST_ROW   = ROW_W'(GRID_SIZE - 1);
  localparam logic [CFG_ADDR_W-1:0] ADDR_START_ROW = CFG_ADDR_W'(REG_START_ROW * 4);
  localparam logic [CFG_ADDR_W-1:0] ADDR_START_COL = CFG_ADDR_W'(REG_START_COL * 4);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_MARK,
    S_PRT_RD,
    S_PRT_WAIT,
    S_OUT
  } state_t;

  state_t state;

  logic [COORD_W-1:0]    start_row;
  logic [COORD_W-1:0]    start_col;
  logic [COORD_W-1:0]    turtle_row;
  logic [COORD_W-1:0]    turtle_col;
  logic [HEAD_W-1:0]     heading;
  logic                  pen;
  logic [DIST_W-1:0]     dist_cnt;
  logic [ROW_W-1:0]      row_cnt;
  logic [GRID_SIZE-1:0]  row_valid;

  logic                  out_valid;
  logic [ROW_DATA_W-1:0] out_row_data;
  logic [COORD_W-1:0]    out_row_number;
  logic                  out_is_row;
  logic                  out_last;

  logic                  cfg_wr;
  logic                  at_edge;
  logic [COORD_W-1:0]    next_row;
  logic [COORD_W-1:0]    next_col;
  logic [ROW_W-1:0]      cur_idx;

  logic                  ram_wr_en;
  logic [ROW_W-1:0]      ram_wr_addr;
  logic [GRID_SIZE-1:0]  ram_wr_data;
  logic                  ram_rd_en;
  logic [ROW_W-1:0]      ram_rd_addr;
  logic [GRID_SIZE-1:0]  ram_rd_data;
  logic [GRID_SIZE-1:0]  row_word;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    return (v > LAST_COORD) ? LAST_COORD : v;
  endfunction

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr)
      ADDR_START_ROW: prdata = CFG_DATA_W'(start_row);
      ADDR_START_COL: prdata = CFG_DATA_W'(start_col);
      default:        prdata = '0;
    endcase
  end

  // Next position one step ahead, and whether that step would leave the grid.
  always_comb begin
    next_row = turtle_row;
    next_col = turtle_col;
    at_edge  = 1'b0;
    case (heading)
      HEAD_ROW_UP: begin
        at_edge  = (turtle_row >= LAST_COORD);
        next_row = turtle_row + COORD_W'(1);
      end
      HEAD_COL_UP: begin
        at_edge  = (turtle_col >= LAST_COORD);
        next_col = turtle_col + COORD_W'(1);
      end
      HEAD_ROW_DOWN: begin
        at_edge  = (turtle_row == '0);
        next_row = turtle_row - COORD_W'(1);
      end
      default: begin
        at_edge  = (turtle_col == '0);
        next_col = turtle_col - COORD_W'(1);
      end
    endcase
  end

  assign cur_idx = turtle_row[ROW_W-1:0];

  // A row never written reads as cleared.
  assign row_word = row_valid[ram_wr_addr] ? ram_rd_data : '0;

  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = row_cnt;
    ram_wr_en   = (state == S_MARK);
    ram_wr_addr = cur_idx;
    ram_wr_data = row_word | ({{(GRID_SIZE-1){1'b0}}, 1'b1} << turtle_col);
    case (state)
      S_MOVE: begin
        ram_rd_en   = pen && (dist_cnt != '0) && !at_edge;
        ram_rd_addr = next_row[ROW_W-1:0];
      end
      S_PRT_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = row_cnt;
      end
      default: begin
        ram_rd_en = 1'b0;
      end
    endcase
  end

  tgp_ram #(
    .WIDTH (GRID_SIZE),
    .DEPTH (GRID_SIZE)
  ) u_grid (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign cmd.ready       = (state == S_IDLE);
  assign res.valid       = out_valid;
  assign res.row_data    = out_row_data;
  assign res.row_number  = out_row_number;
  assign res.is_row      = out_is_row;
  assign res.last        = out_last;
  assign res.cur_row     = turtle_row;
  assign res.cur_col     = turtle_col;
  assign res.cur_heading = heading;
  assign res.pen_is_down = pen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      start_row  <= START_RESET;
      start_col  <= START_RESET;
      turtle_row <= clamp_coord(START_RESET);
      turtle_col <= clamp_coord(START_RESET);
      heading    <= HEAD_ROW_UP;
      pen        <= 1'b0;
      row_valid  <= '0;
      out_valid  <= 1'b0;
      dist_cnt   <= '0;
      row_cnt    <= '0;
    end else begin
      // Start writes also place the turtle at once.
      if (cfg_wr && paddr == ADDR_START_ROW) begin
        start_row  <= pwdata[COORD_W-1:0];
        turtle_row <= clamp_coord(pwdata[COORD_W-1:0]);
      end
      if (cfg_wr && paddr == ADDR_START_COL) begin
        start_col  <= pwdata[COORD_W-1:0];
        turtle_col <= clamp_coord(pwdata[COORD_W-1:0]);
      end

      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            out_row_data   <= '0;
            out_row_number <= '0;
            out_is_row     <= 1'b0;
            out_last       <= 1'b1;
            case (op_t'(cmd.op))
              OP_PEN_UP: begin
                pen       <= 1'b0;
                out_valid <= 1'b1;
                state     <= S_OUT;
              end
              OP_PEN_DOWN: begin
                pen       <= 1'b1;
                out_valid <= 1'b1;
                state     <= S_OUT;
              end
              OP_RIGHT: begin
                heading   <= heading + HEAD_W'(1);
                out_valid <= 1'b1;
                state     <= S_OUT;
              end
              OP_LEFT: begin
                heading   <= heading - HEAD_W'(1);
                out_valid <= 1'b1;
                state     <= S_OUT;
              end
              OP_MOVE: begin
                dist_cnt <= cmd.distance;
                state    <= S_MOVE;
              end
              OP_PRINT: begin
                row_cnt <= '0;
                state   <= S_PRT_RD;
              end
              default: begin
                out_valid <= 1'b1;
                state     <= S_OUT;
              end
            endcase
          end
        end

        S_MOVE: begin
          if (dist_cnt == '0 || at_edge) begin
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            turtle_row <= next_row;
            turtle_col <= next_col;
            dist_cnt   <= dist_cnt - DIST_W'(1);
            if (pen) begin
              state <= S_MARK;
            end
          end
        end

        S_MARK: begin
          row_valid[cur_idx] <= 1'b1;
          state              <= S_MOVE;
        end

        S_PRT_RD: begin
          state <= S_PRT_WAIT;
        end

        S_PRT_WAIT: begin
          out_row_data   <= row_valid[row_cnt] ? ROW_DATA_W'(ram_rd_data) : '0;
          out_row_number <= COORD_W'(row_cnt);
          out_is_row     <= 1'b1;
          out_last       <= (row_cnt == LAST_ROW);
          out_valid      <= 1'b1;
          state          <= S_OUT;
        end

        S_OUT: begin
          if (res.ready) begin
            out_valid <= 1'b0;
            if (out_is_row && !out_last) begin
              row_cnt <= row_cnt + ROW_W'(1);
              state   <= S_PRT_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: bench/tb_turtle_grid_plotter.sv
// ----------------------------------------------------------------------------
// Turtle grid plotter testbench
// Drives pen, turn, move and print commands with random gaps and stalls on
// both channels, sets the start registers between phases and checks every
// result word against a behavioural plotter kept alongside the block.
// ----------------------------------------------------------------------------
module tb_turtle_grid_plotter;
  import tgp_pkg::*;

  localparam int GRID = GRID_SIZE_DEFAULT;
  localparam logic [ROW_DATA_W-1:0] ROW_MASK = {ROW_DATA_W{1'b1}} >> (ROW_DATA_W - GRID);

  // Command codes that the block accepts but treats as no operation.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  // Longest quiet stretch of a correct run is the long result hold below;
  // a pen-down move to the edge or a stalled print row is far shorter.
  localparam int LONG_HOLD   = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_DRAIN = 8;
  localparam int END_DRAIN   = 200;

  typedef struct packed {
    logic [ROW_DATA_W-1:0] row_data;
    logic [COORD_W-1:0]    row_number;
    logic                  is_row;
    logic                  last;
    logic [COORD_W-1:0]    cur_row;
    logic [COORD_W-1:0]    cur_col;
    logic [HEAD_W-1:0]     cur_heading;
    logic                  pen_is_down;
  } plot_word_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [DIST_W-1:0]  steps;
    logic               typed;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [HEAD_W-1:0]  head;
    logic               pen;
  } script_row_t;

  // Opening script from reset (turtle at 24,24 heading row up, pen up).
  // Rows marked typed carry the status word expected; the rest are predicted.
  localparam int SCRIPT_LEN = 23;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{OP_PEN_DOWN, 8'd0,   1'b1, 6'd24, 6'd24, HEAD_ROW_UP,   1'b1},
    '{OP_MOVE,     8'd0,   1'b1, 6'd24, 6'd24, HEAD_ROW_UP,   1'b1},
    '{OP_MOVE,     8'd255, 1'b1, 6'd63, 6'd24, HEAD_ROW_UP,   1'b1},
    '{OP_RIGHT,    8'd0,   1'b1, 6'd63, 6'd24, HEAD_COL_UP,   1'b1},
    '{OP_MOVE,     8'd255, 1'b1, 6'd63, 6'd63, HEAD_COL_UP,   1'b1},
    '{OP_RIGHT,    8'd0,   1'b1, 6'd63, 6'd63, HEAD_ROW_DOWN, 1'b1},
    '{OP_MOVE,     8'd255, 1'b1, 6'd0,  6'd63, HEAD_ROW_DOWN, 1'b1},
    '{OP_RIGHT,    8'd0,   1'b1, 6'd0,  6'd63, HEAD_COL_DOWN, 1'b1},
    '{OP_MOVE,     8'd255, 1'b1, 6'd0,  6'd0,  HEAD_COL_DOWN, 1'b1},
    '{OP_RIGHT,    8'd0,   1'b1, 6'd0,  6'd0,  HEAD_ROW_UP,   1'b1},
    '{OP_LEFT,     8'd0,   1'b1, 6'd0,  6'd0,  HEAD_COL_DOWN, 1'b1},
    '{OP_LEFT,     8'd0,   1'b1, 6'd0,  6'd0,  HEAD_ROW_DOWN, 1'b1},
    '{OP_MOVE,     8'd5,   1'b1, 6'd0,  6'd0,  HEAD_ROW_DOWN, 1'b1},
    '{OP_SPARE_6,  8'd170, 1'b1, 6'd0,  6'd0,  HEAD_ROW_DOWN, 1'b1},
    '{OP_SPARE_7,  8'd85,  1'b1, 6'd0,  6'd0,  HEAD_ROW_DOWN, 1'b1},
    '{OP_PEN_UP,   8'd0,   1'b1, 6'd0,  6'd0,  HEAD_ROW_DOWN, 1'b0},
    '{OP_LEFT,     8'd0,   1'b1, 6'd0,  6'd0,  HEAD_COL_UP,   1'b0},
    '{OP_MOVE,     8'd10,  1'b1, 6'd0,  6'd10, HEAD_COL_UP,   1'b0},
    '{OP_PRINT,    8'd0,   1'b0, 6'd0,  6'd0,  HEAD_ROW_UP,   1'b0},
    '{OP_PEN_DOWN, 8'd0,   1'b1, 6'd0,  6'd10, HEAD_COL_UP,   1'b1},
    '{OP_LEFT,     8'd0,   1'b1, 6'd0,  6'd10, HEAD_ROW_UP,   1'b1},
    '{OP_MOVE,     8'd3,   1'b0, 6'd0,  6'd0,  HEAD_ROW_UP,   1'b0},
    '{OP_PRINT,    8'd0,   1'b0, 6'd0,  6'd0,  HEAD_ROW_UP,   1'b0}
  };

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  tgp_cmd_if cmd ();
  tgp_res_if res ();

  turtle_grid_plotter #(.GRID_SIZE(GRID)) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd),
    .res     (res)
  );

  // Plotter state as the block should hold it.
  logic [ROW_DATA_W-1:0] canvas [GRID];
  logic [COORD_W-1:0]    start_regs [2];
  logic [COORD_W-1:0]    row_st;
  logic [COORD_W-1:0]    col_st;
  logic [HEAD_W-1:0]     heading_st;
  logic                  pen_st;

  plot_word_t pending_words [$];
  int         mismatches;
  int         gap_odds;
  int         sink_stall_odds;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [COORD_W-1:0] clamp_to_grid(input logic [COORD_W-1:0] v);
    return (v > GRID - 1) ? COORD_W'(GRID - 1) : v;
  endfunction

  function automatic plot_word_t status_word(input logic [COORD_W-1:0] r,
                                             input logic [COORD_W-1:0] c,
                                             input logic [HEAD_W-1:0] h,
                                             input logic p);
    plot_word_t w;
    w = '0;
    w.last        = 1'b1;
    w.cur_row     = r;
    w.cur_col     = c;
    w.cur_heading = h;
    w.pen_is_down = p;
    return w;
  endfunction

  // Applies one command to the plotter state and queues the words it yields.
  task automatic plot_command(input logic [OP_W-1:0] op, input logic [DIST_W-1:0] steps);
    plot_word_t w;
    bit         blocked;
    blocked = 1'b0;
    case (op)
      OP_PEN_UP:   pen_st = 1'b0;
      OP_PEN_DOWN: pen_st = 1'b1;
      OP_RIGHT:    heading_st = heading_st + 2'd1;
      OP_LEFT:     heading_st = heading_st - 2'd1;
      OP_MOVE: begin
        for (int n = 0; n < steps && !blocked; n++) begin
          case (heading_st)
            HEAD_ROW_UP:   if (row_st >= GRID - 1) blocked = 1'b1; else row_st++;
            HEAD_COL_UP:   if (col_st >= GRID - 1) blocked = 1'b1; else col_st++;
            HEAD_ROW_DOWN: if (row_st == 0) blocked = 1'b1; else row_st--;
            default:       if (col_st == 0) blocked = 1'b1; else col_st--;
          endcase
          // The cell stepped into is marked; the starting cell never is.
          if (!blocked && pen_st) canvas[row_st][col_st] = 1'b1;
        end
      end
      OP_PRINT: begin
        for (int r = 0; r < GRID; r++) begin
          w = status_word(row_st, col_st, heading_st, pen_st);
          w.row_data   = canvas[r] & ROW_MASK;
          w.row_number = COORD_W'(r);
          w.is_row     = 1'b1;
          w.last       = (r == GRID - 1);
          pending_words.push_back(w);
        end
      end
      default: ;
    endcase
    if (op != OP_PRINT) pending_words.push_back(status_word(row_st, col_st, heading_st, pen_st));
  endtask

  task automatic send_command(input logic [OP_W-1:0] op, input logic [DIST_W-1:0] steps,
                              input bit typed, input plot_word_t typed_word);
    cmd.valid    <= 1'b1;
    cmd.op       <= op;
    cmd.distance <= steps;
    do @(posedge clk); while (!cmd.ready);
    plot_command(op, steps);
    if (typed) pending_words[pending_words.size() - 1] = typed_word;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Writing a start register also moves the turtle there at once; the
  // register is then read back.
  task automatic write_start(input int reg_idx, input logic [COORD_W-1:0] value);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    word[COORD_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * reg_idx);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    start_regs[reg_idx] = value;
    if (reg_idx == REG_START_ROW) row_st = clamp_to_grid(value);
    else col_st = clamp_to_grid(value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    compare_field("prdata", 64'(start_regs[reg_idx]), 64'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_until_idle(input int drain);
    cmd.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (drain) @(posedge clk);
  endtask

  task automatic random_commands(input int count);
    logic [OP_W-1:0]   op;
    logic [DIST_W-1:0] steps;
    int                pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = OP_MOVE;
      else if (pick < 55) op = OP_RIGHT;
      else if (pick < 70) op = OP_LEFT;
      else if (pick < 80) op = OP_PEN_DOWN;
      else if (pick < 88) op = OP_PEN_UP;
      else if (pick < 93) op = OP_PRINT;
      else if (pick < 97) op = OP_SPARE_6;
      else                op = OP_SPARE_7;
      // Mostly short moves so the turtle wanders; now and then a long run.
      pick = $urandom_range(0, 99);
      if (pick < 60)      steps = DIST_W'($urandom_range(0, 12));
      else if (pick < 85) steps = DIST_W'($urandom_range(13, 70));
      else                steps = DIST_W'($urandom);
      send_command(op, steps, 1'b0, '0);
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    plot_word_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected: row_number %0d is_row %0b",
               res.row_number, res.is_row);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        compare_field("row_data", want.row_data, res.row_data);
        compare_field("row_number", 64'(want.row_number), 64'(res.row_number));
        compare_field("is_row", 64'(want.is_row), 64'(res.is_row));
        compare_field("last", 64'(want.last), 64'(res.last));
        compare_field("cur_row", 64'(want.cur_row), 64'(res.cur_row));
        compare_field("cur_col", 64'(want.cur_col), 64'(res.cur_col));
        compare_field("cur_heading", 64'(want.cur_heading), 64'(res.cur_heading));
        compare_field("pen_is_down", 64'(want.pen_is_down), 64'(res.pen_is_down));
      end
    end
  end

  // Result side: short random stalls, plus one long hold while commands keep
  // coming, so that the block backs up and refuses its next command.
  initial begin : result_sink
    int hold_left;
    int taken;
    bit long_done;
    hold_left = 0;
    taken     = 0;
    long_done = 1'b0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res.valid && res.ready) taken++;
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (!long_done && taken >= 300) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        res.ready <= 1'b0;
      end else if (sink_stall_odds != 0 && $urandom_range(1, sink_stall_odds) == 1) begin
        hold_left = $urandom_range(0, 3);
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready) ||
          (psel && penable && pready))
        idle = 0;
      else
        idle++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    cmd.valid       = 1'b0;
    cmd.op          = OP_PEN_UP;
    cmd.distance    = '0;
    mismatches      = 0;
    gap_odds        = 3;
    sink_stall_odds = 3;

    foreach (canvas[r]) canvas[r] = '0;
    start_regs[REG_START_ROW] = START_RESET;
    start_regs[REG_START_COL] = START_RESET;
    row_st     = clamp_to_grid(START_RESET);
    col_st     = clamp_to_grid(START_RESET);
    heading_st = HEAD_ROW_UP;
    pen_st     = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i])
      send_command(SCRIPT[i].op, SCRIPT[i].steps, SCRIPT[i].typed,
                   status_word(SCRIPT[i].row, SCRIPT[i].col, SCRIPT[i].head, SCRIPT[i].pen));
    wait_until_idle(PHASE_DRAIN);

    write_start(REG_START_ROW, COORD_W'(GRID - 1));
    write_start(REG_START_COL, '0);
    random_commands(170);
    wait_until_idle(PHASE_DRAIN);

    gap_odds = 6;
    sink_stall_odds <= 6;
    write_start(REG_START_COL, COORD_W'(GRID - 1));
    write_start(REG_START_ROW, '0);
    random_commands(170);
    wait_until_idle(PHASE_DRAIN);

    gap_odds = 4;
    sink_stall_odds <= 4;
    write_start(REG_START_ROW, COORD_W'($urandom_range(0, 63)));
    write_start(REG_START_COL, COORD_W'($urandom_range(0, 63)));
    random_commands(100);
    // Closing stretch runs flat out on both sides.
    gap_odds = 0;
    sink_stall_odds <= 0;
    random_commands(60);
    wait_until_idle(END_DRAIN);

    if (mismatches == 0 && pending_words.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
